### rtl/pisb_pkg.sv
// ----------------------------------------------------------------------------
// pisb_pkg
// Shared types and constants of the two-wheel speed balancing PI controller.
// ----------------------------------------------------------------------------
package pisb_pkg;

    localparam int SPEED_W = 16;
    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 15;
    localparam int ERR_W   = SPEED_W + 1;
    localparam int SUM_W   = 16;
    localparam int DRIVE_W = 16;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 16;

    typedef enum logic [CFG_AW-1:0] {
        REG_PROP_GAIN      = 2'd0,
        REG_INTEG_GAIN     = 2'd1,
        REG_INTEGRAL_LIMIT = 2'd2,
        REG_DRIVE_LIMIT    = 2'd3
    } cfg_idx_t;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST      = 16'd768;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST     = 16'd256;
    localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 15'd1000;
    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST    = 15'd120;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [SUM_W-1:0] sum;
        logic                    hit;
    } integ_res_t;

endpackage

### rtl/pisb_integ.sv
// ----------------------------------------------------------------------------
// pisb_integ
// Speed error, clamped running integral and its state register.
// ----------------------------------------------------------------------------
module pisb_integ (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic                                clear,
    input  logic signed [pisb_pkg::SPEED_W-1:0] left_speed,
    input  logic signed [pisb_pkg::SPEED_W-1:0] right_speed,
    input  logic        [pisb_pkg::LIMIT_W-1:0] limit,
    output pisb_pkg::integ_res_t                res
);

    logic signed [pisb_pkg::SUM_W-1:0]   error_sum_reg;
    logic signed [pisb_pkg::SUM_W-1:0]   error_sum_next;
    logic signed [pisb_pkg::ERR_W-1:0]   err;
    logic signed [pisb_pkg::ERR_W:0]     raw_sum;
    logic signed [pisb_pkg::ERR_W:0]     lim_pos;
    logic signed [pisb_pkg::ERR_W:0]     lim_neg;
    logic signed [pisb_pkg::SUM_W-1:0]   clamped;
    logic                                hit;

    always_comb
    begin
        err     = {left_speed[pisb_pkg::SPEED_W-1], left_speed}
                - {right_speed[pisb_pkg::SPEED_W-1], right_speed};
        raw_sum = {{2{error_sum_reg[pisb_pkg::SUM_W-1]}}, error_sum_reg}
                + {err[pisb_pkg::ERR_W-1], err};
        lim_pos = {3'b000, limit};
        lim_neg = -lim_pos;
        if (raw_sum > lim_pos)
        begin
            clamped = lim_pos[pisb_pkg::SUM_W-1:0];
            hit     = 1'b1;
        end
        else if (raw_sum < lim_neg)
        begin
            clamped = lim_neg[pisb_pkg::SUM_W-1:0];
            hit     = 1'b1;
        end
        else
        begin
            clamped = raw_sum[pisb_pkg::SUM_W-1:0];
            hit     = 1'b0;
        end
    end

    always_comb
    begin
        error_sum_next = error_sum_reg;
        if (clear)
        begin
            error_sum_next = '0;
        end
        else if (step)
        begin
            error_sum_next = clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg <= '0;
        end
        else
        begin
            error_sum_reg <= error_sum_next;
        end
    end

    // A clear request reports a zero integral and no saturation.
    always_comb
    begin
        res.err = err;
        res.sum = clear ? '0 : clamped;
        res.hit = clear ? 1'b0 : hit;
    end

endmodule

### rtl/pi_speed_balance.sv
// ----------------------------------------------------------------------------
// pi_speed_balance
// Two-wheel speed balancing PI controller with integral and drive clamps.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries the left and right wheel speeds
// and a command in s_tuser: 0 runs a control step, 1 clears the integral.
// Every request yields exactly one result on the master stream: the drive
// correction in m_tdata and the two saturation flags in m_tuser.
// The gains and limits are set through the write port (cfg_we, cfg_addr,
// cfg_data) while no request is in flight; the user must see to this, as the block does not.
// The pipeline has three register stages: the integrator, the two gain
// multipliers, then the sum, truncation and drive clamp. One request is
// accepted in every cycle while s_tready is high; the integral update is
// done in the acceptance cycle, so consecutive requests see each other's
// integral without a gap.
// Reset clears the integral, empties the pipeline and loads the default
// gains (3.0 and 1.0) and limits (1000 and 120).
// When the receiver stalls, the result holds in the output register and
// the pipeline keeps filling its empty stages; s_tready drops only when
// all three stages are occupied.
// ----------------------------------------------------------------------------
module pi_speed_balance (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pisb_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [pisb_pkg::CFG_DW-1:0]        cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,  // left_speed, right_speed
    input  logic [0:0]                         s_tuser,  // command
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pisb_pkg::DRIVE_W-1:0]       m_tdata,  // drive
    output logic [1:0]                         m_tuser   // integral_clamped, drive_clamped
);

    localparam int PP_W  = pisb_pkg::GAIN_W + pisb_pkg::ERR_W;
    localparam int PI_W  = pisb_pkg::GAIN_W + pisb_pkg::SUM_W;
    localparam int ACC_W = PP_W + 1;
    localparam int Q_W   = ACC_W - 8;

    // Configuration registers
    logic signed [pisb_pkg::GAIN_W-1:0]  prop_gain_reg;
    logic signed [pisb_pkg::GAIN_W-1:0]  integ_gain_reg;
    logic        [pisb_pkg::LIMIT_W-1:0] integral_limit_reg;
    logic        [pisb_pkg::LIMIT_W-1:0] drive_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg      <= pisb_pkg::PROP_GAIN_RST;
            integ_gain_reg     <= pisb_pkg::INTEG_GAIN_RST;
            integral_limit_reg <= pisb_pkg::INTEGRAL_LIMIT_RST;
            drive_limit_reg    <= pisb_pkg::DRIVE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (pisb_pkg::cfg_idx_t'(cfg_addr))
                pisb_pkg::REG_PROP_GAIN:      prop_gain_reg      <= cfg_data;
                pisb_pkg::REG_INTEG_GAIN:     integ_gain_reg     <= cfg_data;
                pisb_pkg::REG_INTEGRAL_LIMIT:
                    integral_limit_reg <= cfg_data[pisb_pkg::LIMIT_W-1:0];
                pisb_pkg::REG_DRIVE_LIMIT:
                    drive_limit_reg <= cfg_data[pisb_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    logic v1_reg, v2_reg, out_v_reg;
    logic rdy_out, rdy2, rdy1, accept;

    assign rdy_out  = !out_v_reg || m_tready;
    assign rdy2     = !v2_reg || rdy_out;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign accept   = s_tvalid && rdy1;

    // Stage 1: error and integral
    pisb_pkg::integ_res_t integ_res;

    pisb_integ u_integ (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept && !s_tuser[0]),
        .clear       (accept && s_tuser[0]),
        .left_speed  (s_tdata[15:0]),
        .right_speed (s_tdata[31:16]),
        .limit       (integral_limit_reg),
        .res         (integ_res)
    );

    logic signed [pisb_pkg::ERR_W-1:0] err1_reg;
    logic signed [pisb_pkg::SUM_W-1:0] sum1_reg;
    logic                              ihit1_reg;
    logic                              cmd1_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err1_reg  <= integ_res.err;
            sum1_reg  <= integ_res.sum;
            ihit1_reg <= integ_res.hit;
            cmd1_reg  <= s_tuser[0];
        end
    end

    // Stage 2: gain products
    logic signed [PP_W-1:0] prod_p_next, prod_p_reg;
    logic signed [PI_W-1:0] prod_i_next, prod_i_reg;
    logic                   ihit2_reg;
    logic                   cmd2_reg;
    logic                   adv2;

    assign prod_p_next = prop_gain_reg * err1_reg;
    assign prod_i_next = integ_gain_reg * sum1_reg;
    assign adv2        = v1_reg && rdy2;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            ihit2_reg  <= ihit1_reg;
            cmd2_reg   <= cmd1_reg;
        end
    end

    // Stage 3: sum, divide by 256 toward zero, drive clamp
    logic signed [ACC_W-1:0]            acc;
    logic signed [ACC_W-1:0]            acc_adj;
    logic signed [Q_W-1:0]              quot;
    logic signed [Q_W-1:0]              dlim_pos;
    logic signed [Q_W-1:0]              dlim_neg;
    logic signed [pisb_pkg::DRIVE_W-1:0] drive_next;
    logic                               dhit_next;
    logic                               adv3;

    always_comb
    begin
        acc      = {prod_p_reg[PP_W-1], prod_p_reg}
                 + {{(ACC_W-PI_W){prod_i_reg[PI_W-1]}}, prod_i_reg};
        acc_adj  = acc + (acc[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
        quot     = acc_adj[ACC_W-1:8];
        dlim_pos = {{(Q_W-pisb_pkg::LIMIT_W){1'b0}}, drive_limit_reg};
        dlim_neg = -dlim_pos;
        if (cmd2_reg)
        begin
            drive_next = '0;
            dhit_next  = 1'b0;
        end
        else if (quot > dlim_pos)
        begin
            drive_next = dlim_pos[pisb_pkg::DRIVE_W-1:0];
            dhit_next  = 1'b1;
        end
        else if (quot < dlim_neg)
        begin
            drive_next = dlim_neg[pisb_pkg::DRIVE_W-1:0];
            dhit_next  = 1'b1;
        end
        else
        begin
            drive_next = quot[pisb_pkg::DRIVE_W-1:0];
            dhit_next  = 1'b0;
        end
    end

    assign adv3 = v2_reg && rdy_out;

    logic [pisb_pkg::DRIVE_W-1:0] drive_reg;
    logic                         ihit_out_reg;
    logic                         dhit_out_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            drive_reg    <= drive_next;
            ihit_out_reg <= ihit2_reg;
            dhit_out_reg <= dhit_next;
        end
    end

    // Stage valid bits
    logic v1_next, v2_next, out_v_next;

    always_comb
    begin
        v1_next    = accept ? 1'b1 : (adv2 ? 1'b0 : v1_reg);
        v2_next    = adv2 ? 1'b1 : (adv3 ? 1'b0 : v2_reg);
        out_v_next = adv3 ? 1'b1 : ((out_v_reg && m_tready) ? 1'b0 : out_v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            out_v_reg <= out_v_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = drive_reg;
    assign m_tuser  = {dhit_out_reg, ihit_out_reg};

`ifndef SYNTHESIS
    // A clear request lands in stage 1 with a zero integral and no flag.
    a_clear_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> v1_reg && sum1_reg == '0 && !ihit1_reg)
        else $error("clear request did not zero the integral");

    // A clear that reaches the output stage gives a zero drive and no flags.
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv3 && cmd2_reg |=> m_tvalid && m_tdata == '0 && m_tuser == 2'b00)
        else $error("clear result is not zero");

    // Input backpressure only when every stage holds a request.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> v1_reg && v2_reg && out_v_reg && !m_tready)
        else $error("input stalled with an empty stage");
`endif

endmodule
